FILE: sv/gcit_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcit_pkg
// Shared widths, reset values and request codes of the centroid id tracker.
// ----------------------------------------------------------------------------
package gcit_pkg;

  // request code field
  localparam int unsigned FUNC_W      = 2;
  localparam logic [FUNC_W-1:0] FUNC_BOX   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EMPTY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // fixed field widths
  localparam int unsigned RADIUS_W    = 12;
  localparam int unsigned IDENT_W     = 31;
  localparam int unsigned BOX_INDEX_W = 5;

  // most boxes kept per frame, bounded by the result index range
  localparam int unsigned CAP_LIMIT   = 32;

  // match radius after reset
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd50;

endpackage

`default_nettype wire

FILE: sv/gcit_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcit_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcit_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: sv/gcit_dist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcit_dist
// Pipelined squared center distance: absolute differences, then squares.
// The final sum is formed combinationally from the square registers.
// ----------------------------------------------------------------------------
module gcit_dist #(
  parameter int unsigned CW = 13,
  parameter int unsigned IW = 5
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [IW-1:0]   idx_i,
  input  wire logic [CW-1:0]   ax_i,
  input  wire logic [CW-1:0]   ay_i,
  input  wire logic [CW-1:0]   bx_i,
  input  wire logic [CW-1:0]   by_i,
  output      logic            valid_o,
  output      logic [IW-1:0]   idx_o,
  output      logic [2*CW:0]   dist_o,
  output      logic            busy_o
);

  logic            s1_v_q, s2_v_q;
  logic [IW-1:0]   s1_idx_q, s2_idx_q;
  logic [CW-1:0]   dx_q, dy_q;
  logic [2*CW-1:0] sqx_q, sqy_q;
  logic [CW-1:0]   dx_d, dy_d;

  // absolute differences
  always_comb begin
    dx_d = (ax_i >= bx_i) ? (ax_i - bx_i) : (bx_i - ax_i);
    dy_d = (ay_i >= by_i) ? (ay_i - by_i) : (by_i - ay_i);
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
    end
  end

  // difference and square registers
  always_ff @(posedge clk_i) begin
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    s1_idx_q <= idx_i;
    sqx_q    <= {{CW{1'b0}}, dx_q} * {{CW{1'b0}}, dx_q};
    sqy_q    <= {{CW{1'b0}}, dy_q} * {{CW{1'b0}}, dy_q};
    s2_idx_q <= s1_idx_q;
  end

  assign valid_o = s2_v_q;
  assign idx_o   = s2_idx_q;
  assign dist_o  = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign busy_o  = s1_v_q | s2_v_q;

endmodule

`default_nettype wire

FILE: sv/greedy_centroid_id_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_centroid_id_tracker
// Greedy nearest neighbor tracker that hands object ids to box centers.
// ----------------------------------------------------------------------------
// Input requests (valid/ready) carry one box each; the box with last_in_frame
// closes the frame. At frame end a sequencer takes each previous object in
// turn and streams the current boxes through one shared distance pipeline,
// keeping the nearest unmatched box below the radius.
// in_ready_o is low from the closing box until the last result is registered.
// Results (valid/ready) leave through an output register, one per box; while
// the receiver stalls, the sequencer waits with the next result. Reset clears
// all tracking state and sets the radius to 50. The user writes the radius
// via cfg_we_i/cfg_wdata_i only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module greedy_centroid_id_tracker
  import gcit_pkg::*;
#(
  parameter int unsigned MAX_BOXES  = 32,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // box requests
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire logic [FUNC_W-1:0]      func_i,
  input  wire logic [COORD_BITS-1:0]  box_x_i,
  input  wire logic [COORD_BITS-1:0]  box_y_i,
  input  wire logic [COORD_BITS-1:0]  box_w_i,
  input  wire logic [COORD_BITS-1:0]  box_h_i,
  input  wire logic                   last_in_frame_i,
  // results
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      logic [BOX_INDEX_W-1:0] box_index_o,
  output      logic [IDENT_W-1:0]     track_id_o,
  output      logic                   last_result_o,
  output      logic                   overflowed_o,
  // radius register
  input  wire logic                   cfg_we_i,
  input  wire logic [RADIUS_W-1:0]    cfg_wdata_i
);

  localparam int unsigned CAP    = (MAX_BOXES < CAP_LIMIT) ? MAX_BOXES : CAP_LIMIT;
  localparam int unsigned IW     = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int unsigned CNTW   = $clog2(CAP + 1);
  localparam int unsigned CW     = COORD_BITS + 1;
  localparam int unsigned DW     = 2 * CW + 1;
  localparam int unsigned LW     = 2 * RADIUS_W;
  localparam int unsigned BW     = (DW > LW) ? DW : LW;
  localparam int unsigned CDEPTH = 2 ** (IW + 1);
  localparam int unsigned IDEPTH = 2 ** IW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIMIT,
    S_PREV_RD,
    S_PREV_LD,
    S_SWEEP,
    S_COMMIT,
    S_EMIT
  } state_e;

  // control state
  state_e                 state_q, state_d;
  logic [RADIUS_W-1:0]    radius_q, radius_d;
  logic                   bank_q, bank_d;
  logic [CNTW-1:0]        cur_cnt_q, cur_cnt_d;
  logic [CNTW-1:0]        prev_cnt_q, prev_cnt_d;
  logic [IDENT_W-1:0]     next_id_q, next_id_d;
  logic                   drop_q, drop_d;
  logic [CNTW-1:0]        p_q, p_d;
  logic [CNTW-1:0]        i_q, i_d;
  logic                   iss_v_q, iss_v_d;
  logic                   found_q, found_d;
  logic [CAP-1:0]         matched_q, matched_d;
  logic                   out_valid_q, out_valid_d;
  logic [BOX_INDEX_W-1:0] out_idx_q, out_idx_d;
  logic [IDENT_W-1:0]     out_id_q, out_id_d;
  logic                   out_last_q, out_last_d;
  logic                   out_ovf_q, out_ovf_d;

  // datapath registers
  logic [LW-1:0]          limit_q, limit_d;
  logic [CW-1:0]          prev_x_q, prev_x_d;
  logic [CW-1:0]          prev_y_q, prev_y_d;
  logic [IDENT_W-1:0]     prev_id_q, prev_id_d;
  logic [BW-1:0]          best_q, best_d;
  logic [IW-1:0]          pick_q, pick_d;
  logic [IW-1:0]          iss_idx_q, iss_idx_d;
  logic [IDENT_W-1:0]     cur_id_q [CAP];

  // memory and distance unit wiring
  logic                   in_fire;
  logic                   store_box;
  logic [CW-1:0]          cx, cy;
  logic [IW:0]            c_raddr;
  logic [2*CW-1:0]        c_rdata;
  logic                   id_we;
  logic [IDENT_W-1:0]     id_rdata;
  logic [IW-1:0]          i_idx;
  logic [IDENT_W-1:0]     emit_id;
  logic                   dist_v;
  logic [IW-1:0]          dist_idx;
  logic [DW-1:0]          dist_sum;
  logic                   dist_busy;
  logic                   emit_slot;
  logic                   emit_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign store_box  = in_fire && (func_i == FUNC_BOX) && (cur_cnt_q < CNTW'(CAP));
  assign i_idx      = i_q[IW-1:0];

  // box centers with truncated halving
  assign cx = {1'b0, box_x_i} + {2'b0, box_w_i[COORD_BITS-1:1]};
  assign cy = {1'b0, box_y_i} + {2'b0, box_h_i[COORD_BITS-1:1]};

  // center store, two banks swapped at frame end
  assign c_raddr = (state_q == S_PREV_RD) ? {~bank_q, p_q[IW-1:0]} : {bank_q, i_idx};

  gcit_ram #(
    .WIDTH (2 * CW),
    .DEPTH (CDEPTH)
  ) u_center_ram (
    .clk_i   (clk_i),
    .we_i    (store_box),
    .waddr_i ({bank_q, cur_cnt_q[IW-1:0]}),
    .wdata_i ({cy, cx}),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // ids of the previous frame, written as results go out
  gcit_ram #(
    .WIDTH (IDENT_W),
    .DEPTH (IDEPTH)
  ) u_ident_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (i_idx),
    .wdata_i (emit_id),
    .raddr_i (p_q[IW-1:0]),
    .rdata_o (id_rdata)
  );

  // shared distance pipeline
  gcit_dist #(
    .CW (CW),
    .IW (IW)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (iss_v_q),
    .idx_i   (iss_idx_q),
    .ax_i    (c_rdata[CW-1:0]),
    .ay_i    (c_rdata[2*CW-1:CW]),
    .bx_i    (prev_x_q),
    .by_i    (prev_y_q),
    .valid_o (dist_v),
    .idx_o   (dist_idx),
    .dist_o  (dist_sum),
    .busy_o  (dist_busy)
  );

  // result for the box under the emit counter
  assign emit_id   = matched_q[i_idx] ? cur_id_q[i_idx] : next_id_q;
  assign emit_slot = !out_valid_q || out_ready_i;
  assign emit_last = (CNTW'(i_q + 1'b1) == cur_cnt_q);
  assign id_we     = (state_q == S_EMIT) && emit_slot;

  // sequencer
  always_comb begin
    state_d     = state_q;
    radius_d    = radius_q;
    bank_d      = bank_q;
    cur_cnt_d   = cur_cnt_q;
    prev_cnt_d  = prev_cnt_q;
    next_id_d   = next_id_q;
    drop_d      = drop_q;
    p_d         = p_q;
    i_d         = i_q;
    found_d     = found_q;
    matched_d   = matched_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d   = out_idx_q;
    out_id_d    = out_id_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    limit_d     = limit_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    prev_id_d   = prev_id_q;
    best_d      = best_q;
    pick_d      = pick_q;
    iss_v_d     = (state_q == S_SWEEP) && (i_q < cur_cnt_q);
    iss_idx_d   = i_idx;

    if (cfg_we_i) begin
      radius_d = cfg_wdata_i;
    end

    // nearest unmatched candidate, first index wins ties
    if (dist_v && !matched_q[dist_idx] && (BW'(dist_sum) < best_q)) begin
      best_d  = BW'(dist_sum);
      pick_d  = dist_idx;
      found_d = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (func_i)
            FUNC_BOX: begin
              if (cur_cnt_q < CNTW'(CAP)) begin
                cur_cnt_d = CNTW'(cur_cnt_q + 1'b1);
              end else begin
                drop_d = 1'b1;
              end
              if (last_in_frame_i) begin
                state_d = S_LIMIT;
              end
            end
            FUNC_EMPTY: begin
              prev_cnt_d = '0;
              cur_cnt_d  = '0;
              drop_d     = 1'b0;
            end
            FUNC_CLEAR: begin
              prev_cnt_d = '0;
              cur_cnt_d  = '0;
              drop_d     = 1'b0;
              next_id_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_LIMIT: begin
        limit_d = {{RADIUS_W{1'b0}}, radius_q} * {{RADIUS_W{1'b0}}, radius_q};
        p_d     = '0;
        i_d     = '0;
        state_d = (prev_cnt_q == '0) ? S_EMIT : S_PREV_RD;
      end
      S_PREV_RD: begin
        state_d = S_PREV_LD;
      end
      S_PREV_LD: begin
        prev_x_d  = c_rdata[CW-1:0];
        prev_y_d  = c_rdata[2*CW-1:CW];
        prev_id_d = id_rdata;
        best_d    = BW'(limit_q);
        pick_d    = '0;
        found_d   = 1'b0;
        i_d       = '0;
        state_d   = S_SWEEP;
      end
      S_SWEEP: begin
        if (i_q < cur_cnt_q) begin
          i_d = CNTW'(i_q + 1'b1);
        end else if (!iss_v_q && !dist_busy) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (found_q) begin
          matched_d[pick_q] = 1'b1;
        end
        p_d = CNTW'(p_q + 1'b1);
        i_d = '0;
        if (CNTW'(p_q + 1'b1) == prev_cnt_q) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_PREV_RD;
        end
      end
      S_EMIT: begin
        if (emit_slot) begin
          out_valid_d = 1'b1;
          out_idx_d   = BOX_INDEX_W'(i_q);
          out_id_d    = emit_id;
          out_last_d  = emit_last;
          out_ovf_d   = drop_q;
          if (!matched_q[i_idx]) begin
            next_id_d = next_id_q + 1'b1;
          end
          i_d = CNTW'(i_q + 1'b1);
          if (emit_last) begin
            prev_cnt_d = cur_cnt_q;
            cur_cnt_d  = '0;
            drop_d     = 1'b0;
            bank_d     = ~bank_q;
            matched_d  = '0;
            state_d    = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radius_q    <= RADIUS_RESET;
      bank_q      <= 1'b0;
      cur_cnt_q   <= '0;
      prev_cnt_q  <= '0;
      next_id_q   <= '0;
      drop_q      <= 1'b0;
      p_q         <= '0;
      i_q         <= '0;
      iss_v_q     <= 1'b0;
      found_q     <= 1'b0;
      matched_q   <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_id_q    <= '0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      radius_q    <= radius_d;
      bank_q      <= bank_d;
      cur_cnt_q   <= cur_cnt_d;
      prev_cnt_q  <= prev_cnt_d;
      next_id_q   <= next_id_d;
      drop_q      <= drop_d;
      p_q         <= p_d;
      i_q         <= i_d;
      iss_v_q     <= iss_v_d;
      found_q     <= found_d;
      matched_q   <= matched_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      out_id_q    <= out_id_d;
      out_last_q  <= out_last_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  // datapath registers and inherited ids
  always_ff @(posedge clk_i) begin
    limit_q   <= limit_d;
    prev_x_q  <= prev_x_d;
    prev_y_q  <= prev_y_d;
    prev_id_q <= prev_id_d;
    best_q    <= best_d;
    pick_q    <= pick_d;
    iss_idx_q <= iss_idx_d;
    if ((state_q == S_COMMIT) && found_q) begin
      cur_id_q[pick_q] <= prev_id_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign box_index_o   = out_idx_q;
  assign track_id_o    = out_id_q;
  assign last_result_o = out_last_q;
  assign overflowed_o  = out_ovf_q;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the greedy centroid id tracker against a predictor of its own.
// Boxes go in over a valid/ready port with random gaps. Each accepted request
// updates the predicted tracker state, and every frame close queues the ids
// expected for the stored boxes. Results come out against a receiver that
// stalls at random and once holds off for a long stretch. Each result is
// compared field by field with the oldest expectation. The run covers hand
// picked corner cases, moving scenes at several match radii, overflowing
// frames and stray request codes.
// ----------------------------------------------------------------------------
module testbench;
  import gcit_pkg::*;

  localparam int unsigned COORD_W      = 12;
  localparam int unsigned BOX_CAP      = CAP_LIMIT;
  localparam int unsigned SCENE_MAX    = 16;
  localparam int unsigned FRAME_SETTLE = 64;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned MAX_REPORTS  = 100;
  localparam int unsigned TIMEOUT      = 2000000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = 12'd4095;

  typedef logic [COORD_W:0] center_t;
  typedef logic [IDENT_W-1:0] ident_t;

  typedef struct packed {
    logic [BOX_INDEX_W-1:0] box_index;
    ident_t                 track_id;
    logic                   last_result;
    logic                   overflowed;
  } id_result_t;

  // dut ports
  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [FUNC_W-1:0]      func_i;
  logic [COORD_W-1:0]     box_x_i;
  logic [COORD_W-1:0]     box_y_i;
  logic [COORD_W-1:0]     box_w_i;
  logic [COORD_W-1:0]     box_h_i;
  logic                   last_in_frame_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [BOX_INDEX_W-1:0] box_index_o;
  logic [IDENT_W-1:0]     track_id_o;
  logic                   last_result_o;
  logic                   overflowed_o;
  logic                   cfg_we_i;
  logic [RADIUS_W-1:0]    cfg_wdata_i;

  // predicted tracker state
  logic [RADIUS_W-1:0] radius_q;
  center_t             prev_cx [BOX_CAP];
  center_t             prev_cy [BOX_CAP];
  ident_t              prev_id [BOX_CAP];
  int unsigned         prev_n;
  center_t             cur_cx [BOX_CAP];
  center_t             cur_cy [BOX_CAP];
  ident_t              cur_id [BOX_CAP];
  int unsigned         cur_n;
  ident_t              ident_counter;
  bit                  drop_seen;
  id_result_t          expected_ids [$];

  // stimulus control
  bit          gaps_on = 1'b0;
  int unsigned long_hold = 0;
  int unsigned request_count = 0;
  int unsigned error_count = 0;
  int          scene_x [SCENE_MAX];
  int          scene_y [SCENE_MAX];
  int          scene_n;

  greedy_centroid_id_tracker #(
    .MAX_BOXES  (32),
    .COORD_BITS (COORD_W)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .box_x_i         (box_x_i),
    .box_y_i         (box_y_i),
    .box_w_i         (box_w_i),
    .box_h_i         (box_h_i),
    .last_in_frame_i (last_in_frame_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .box_index_o     (box_index_o),
    .track_id_o      (track_id_o),
    .last_result_o   (last_result_o),
    .overflowed_o    (overflowed_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #TIMEOUT;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (error_count < MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  // random field values
  function automatic logic [COORD_W-1:0] rnd_coord();
    return COORD_W'($urandom);
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom);
  endfunction

  // tracker state back to its cleared form, radius kept
  function automatic void reset_tracker();
    prev_n        = 0;
    cur_n         = 0;
    ident_counter = '0;
    drop_seen     = 1'b0;
  endfunction

  // greedy matching of the previous objects, then new ids and results
  function automatic void assign_frame_ids();
    longint unsigned limit, best, d, dx, dy;
    int unsigned     pick;
    bit              found;
    bit              taken [BOX_CAP];
    id_result_t      r;
    limit = longint'(radius_q) * longint'(radius_q);
    for (int unsigned i = 0; i < BOX_CAP; i++) taken[i] = 1'b0;
    for (int unsigned p = 0; p < prev_n; p++) begin
      best  = limit;
      pick  = 0;
      found = 1'b0;
      for (int unsigned i = 0; i < cur_n; i++) begin
        if (!taken[i]) begin
          if (cur_cx[i] > prev_cx[p]) dx = cur_cx[i] - prev_cx[p];
          else dx = prev_cx[p] - cur_cx[i];
          if (cur_cy[i] > prev_cy[p]) dy = cur_cy[i] - prev_cy[p];
          else dy = prev_cy[p] - cur_cy[i];
          d = dx * dx + dy * dy;
          if (d < best) begin
            best  = d;
            pick  = i;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        cur_id[pick] = prev_id[p];
        taken[pick]  = 1'b1;
      end
    end
    for (int unsigned i = 0; i < cur_n; i++) begin
      if (!taken[i]) begin
        cur_id[i]     = ident_counter;
        ident_counter = ident_counter + 1'b1;
      end
      r.box_index   = i[BOX_INDEX_W-1:0];
      r.track_id    = cur_id[i];
      r.last_result = (i + 1 == cur_n);
      r.overflowed  = drop_seen;
      expected_ids.push_back(r);
      prev_cx[i] = cur_cx[i];
      prev_cy[i] = cur_cy[i];
      prev_id[i] = cur_id[i];
    end
    prev_n    = cur_n;
    cur_n     = 0;
    drop_seen = 1'b0;
  endfunction

  // predicted effect of one accepted request
  function automatic void track_request(input logic [FUNC_W-1:0] func,
                                        input logic [COORD_W-1:0] x, y, w, h,
                                        input logic last);
    case (func)
      FUNC_BOX: begin
        if (cur_n < BOX_CAP) begin
          cur_cx[cur_n] = center_t'(x) + center_t'(w >> 1);
          cur_cy[cur_n] = center_t'(y) + center_t'(h >> 1);
          cur_id[cur_n] = '0;
          cur_n++;
        end else begin
          drop_seen = 1'b1;
        end
        if (last) assign_frame_ids();
      end
      FUNC_EMPTY: begin
        prev_n    = 0;
        cur_n     = 0;
        drop_seen = 1'b0;
      end
      FUNC_CLEAR: reset_tracker();
      default: ;
    endcase
  endfunction

  // one request over the input handshake, entered and left at a falling edge
  task automatic send_request(input logic [FUNC_W-1:0] func,
                              input logic [COORD_W-1:0] x, y, w, h,
                              input logic last);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    func_i          = func;
    box_x_i         = x;
    box_y_i         = y;
    box_w_i         = w;
    box_h_i         = h;
    last_in_frame_i = last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_request(func, x, y, w, h, last);
    if (func != FUNC_UNUSED) request_count++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // hold the sender until every queued id is back and the block is quiet
  task automatic wait_drained();
    while (expected_ids.size() != 0) @(posedge clk_i);
    repeat (FRAME_SETTLE) @(negedge clk_i);
  endtask

  task automatic set_radius(input logic [RADIUS_W-1:0] value);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    radius_q = value;
  endtask

  // moving scene frames with random order, mixed with noise requests
  task automatic track_scene(input int unsigned items, input int drift,
                             input int unsigned size_max);
    int unsigned stop_at, roll, parts;
    int          k, j, tmp, v;
    int          order [SCENE_MAX];
    stop_at = request_count + items;
    while (request_count < stop_at) begin
      roll = $urandom_range(0, 15);
      if (roll == 0) begin
        // stray request code
        send_request(FUNC_UNUSED, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                     rnd_bit());
      end else if (roll == 1) begin
        // partial frame thrown away by an empty frame marker
        parts = $urandom_range(0, 3);
        repeat (parts)
          send_request(FUNC_BOX, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), 1'b0);
        send_request(FUNC_EMPTY, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                     rnd_bit());
      end else if (roll == 2 && $urandom_range(0, 3) == 0) begin
        send_request(FUNC_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                     rnd_bit());
      end else if (roll == 3) begin
        // lone box anywhere in the field
        send_request(FUNC_BOX, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), 1'b1);
      end else begin
        // objects leave and enter now and then
        if (scene_n > 1 && $urandom_range(0, 3) == 0) begin
          k          = $urandom_range(0, scene_n - 1);
          scene_x[k] = scene_x[scene_n - 1];
          scene_y[k] = scene_y[scene_n - 1];
          scene_n--;
        end
        if (scene_n < SCENE_MAX && $urandom_range(0, 3) == 0) begin
          scene_x[scene_n] = $urandom_range(0, 4095);
          scene_y[scene_n] = $urandom_range(0, 4095);
          scene_n++;
        end
        // small moves, clamped to the field
        for (k = 0; k < scene_n; k++) begin
          v = scene_x[k] + $urandom_range(0, 2 * drift) - drift;
          scene_x[k] = (v < 0) ? 0 : (v > 4095) ? 4095 : v;
          v = scene_y[k] + $urandom_range(0, 2 * drift) - drift;
          scene_y[k] = (v < 0) ? 0 : (v > 4095) ? 4095 : v;
          order[k] = k;
        end
        for (k = scene_n - 1; k > 0; k--) begin
          j        = $urandom_range(0, k);
          tmp      = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        for (k = 0; k < scene_n; k++) begin
          if ($urandom_range(0, 19) == 0)
            send_request(FUNC_UNUSED, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                         rnd_bit());
          send_request(FUNC_BOX, COORD_W'(scene_x[order[k]]), COORD_W'(scene_y[order[k]]),
                       COORD_W'($urandom_range(0, size_max)),
                       COORD_W'($urandom_range(0, size_max)),
                       k == scene_n - 1);
        end
      end
    end
  endtask

  // hand picked corners: field extremes, ties, radius edge, empty and clear
  task automatic test_directed();
    // corners of the field, both boxes new
    send_request(FUNC_BOX, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    send_request(FUNC_BOX, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1);
    // same objects shifted a little and sent in swapped order
    send_request(FUNC_BOX, 12'd4090, 12'd4095, 12'd4095, 12'd4095, 1'b0);
    send_request(FUNC_BOX, 12'd3, 12'd4, 12'd1, 12'd1, 1'b1);
    // odd size, halving truncates to center 100,100
    send_request(FUNC_BOX, 12'd99, 12'd100, 12'd3, 12'd1, 1'b1);
    // two boxes at the same distance, lower index wins; stray code with last mark
    send_request(FUNC_BOX, 12'd90, 12'd100, 12'd0, 12'd0, 1'b0);
    send_request(FUNC_UNUSED, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1);
    send_request(FUNC_BOX, 12'd110, 12'd100, 12'd0, 12'd0, 1'b1);
    // distance equal to the radius does not match, just below does
    send_request(FUNC_BOX, 12'd90, 12'd150, 12'd0, 12'd0, 1'b0);
    send_request(FUNC_BOX, 12'd110, 12'd149, 12'd0, 12'd0, 1'b1);
    // partial frame discarded by an empty frame, previous list gone
    send_request(FUNC_BOX, 12'd5, 12'd5, 12'd0, 12'd0, 1'b0);
    send_request(FUNC_EMPTY, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1);
    send_request(FUNC_BOX, 12'd110, 12'd149, 12'd0, 12'd0, 1'b1);
    // clear restarts the id counter
    send_request(FUNC_CLEAR, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1);
    send_request(FUNC_BOX, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1);
    // empty frame with nothing loaded
    send_request(FUNC_EMPTY, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    send_request(FUNC_BOX, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1);
  endtask

  // tracking at the reset radius and at several written radii
  task automatic test_radius_sweep();
    track_scene(30, 6, 15);
    set_radius(RADIUS_W'($urandom_range(2, 4094)));
    track_scene(20, 40, 15);
    // only exact center hits match
    set_radius(12'd1);
    track_scene(15, 0, 1);
    // nothing can match
    set_radius(12'd0);
    track_scene(10, 6, 15);
    set_radius(RADIUS_MAX);
    track_scene(20, 200, 15);
  endtask

  // frames past capacity, including a dropped closing box
  task automatic test_capacity();
    int k;
    for (k = 0; k <= BOX_CAP; k++)
      send_request(FUNC_BOX, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                   k == BOX_CAP);
    // full previous list against a full current frame, two boxes dropped
    for (k = 0; k <= BOX_CAP + 1; k++)
      send_request(FUNC_BOX, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                   k == BOX_CAP + 1);
    // flag gone on the next frame
    send_request(FUNC_BOX, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), 1'b0);
    send_request(FUNC_BOX, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), 1'b1);
  endtask

  // receiver holds off while frames keep coming, then sender waits it out
  task automatic test_backpressure();
    set_radius(12'd50);
    long_hold = LONG_HOLD;
    track_scene(20, 4, 15);
    wait_drained();
    track_scene(10, 4, 15);
  endtask

  // last stretch with no idling on either side
  task automatic test_steady_stream();
    wait_drained();
    gaps_on = 1'b0;
    set_radius(RADIUS_W'($urandom_range(20, 200)));
    track_scene(25, 6, 15);
  endtask

  // result receiver with random stalls and the long hold-off
  initial begin : result_receiver
    int unsigned hold;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold != 0) begin
        hold        = long_hold;
        long_hold   = 0;
        out_ready_i = 1'b0;
        repeat (hold - 1) @(negedge clk_i);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        hold        = $urandom_range(1, 14);
        out_ready_i = 1'b0;
        repeat (hold - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest expected id
  always @(posedge clk_i) begin : check_results
    id_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_ids.size() == 0) begin
        report_mismatch($sformatf("result for box %0d with none expected", box_index_o));
      end else begin
        want = expected_ids.pop_front();
        if (box_index_o !== want.box_index)
          report_mismatch($sformatf("box_index got %0d want %0d",
                                    box_index_o, want.box_index));
        if (track_id_o !== want.track_id)
          report_mismatch($sformatf("track_id of box %0d got %0d want %0d",
                                    want.box_index, track_id_o, want.track_id));
        if (last_result_o !== want.last_result)
          report_mismatch($sformatf("last_result of box %0d got %b want %b",
                                    want.box_index, last_result_o, want.last_result));
        if (overflowed_o !== want.overflowed)
          report_mismatch($sformatf("overflowed of box %0d got %b want %b",
                                    want.box_index, overflowed_o, want.overflowed));
      end
    end
  end

  // main sequence
  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    func_i          = FUNC_BOX;
    box_x_i         = '0;
    box_y_i         = '0;
    box_w_i         = '0;
    box_h_i         = '0;
    last_in_frame_i = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    radius_q        = RADIUS_RESET;
    reset_tracker();
    scene_n = $urandom_range(3, 8);
    for (int k = 0; k < SCENE_MAX; k++) begin
      scene_x[k] = $urandom_range(0, 4095);
      scene_y[k] = $urandom_range(0, 4095);
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni  = 1'b1;
    gaps_on = 1'b1;

    test_directed();
    test_radius_sweep();
    test_capacity();
    test_backpressure();
    test_steady_stream();
    wait_drained();

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
